### hdl/jsu_pkg.sv
// ============================================================================
// jsu_pkg: shared types and helpers for the JSON string unescaper
// Result kinds, error codes, the result group type and the small decode
// functions used by the decoder and the result emitter.
// ============================================================================
package jsu_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_TOKEN   = 3'd1;
  localparam logic [2:0] ERR_END     = 3'd2;
  localparam logic [2:0] ERR_ESCAPE  = 3'd3;
  localparam logic [2:0] ERR_UNICODE = 3'd4;

  // Up to four results caused by one input item; num is the count minus one.
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [1:0]      num;
    logic [1:0]      kind;
    logic [2:0]      err;
  } grp_t;

  // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  function automatic hex_t hex_value(input logic [7:0] b);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if ((b >= 8'h30) && (b <= 8'h39)) begin
      h.val = b[3:0];
    end else if (((b >= 8'h41) && (b <= 8'h46)) || ((b >= 8'h61) && (b <= 8'h66))) begin
      h.val = b[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  // A group holding one result.
  function automatic grp_t single(input logic [7:0] b, input logic [1:0] kind,
                                  input logic [2:0] err);
    grp_t g;
    g.data    = '0;
    g.data[0] = b;
    g.num     = 2'd0;
    g.kind    = kind;
    g.err     = err;
    return g;
  endfunction

  // UTF-8 encoding of a code point, first byte in data[0].
  function automatic grp_t utf8(input logic [20:0] cp);
    grp_t g;
    g.data = '0;
    g.kind = KIND_BYTE;
    g.err  = ERR_NONE;
    if (cp <= 21'h7F) begin
      g.data[0] = cp[7:0];
      g.num     = 2'd0;
    end else if (cp <= 21'h7FF) begin
      g.data[0] = {3'b110, cp[10:6]};
      g.data[1] = {2'b10, cp[5:0]};
      g.num     = 2'd1;
    end else if (cp <= 21'hFFFF) begin
      g.data[0] = {4'b1110, cp[15:12]};
      g.data[1] = {2'b10, cp[11:6]};
      g.data[2] = {2'b10, cp[5:0]};
      g.num     = 2'd2;
    end else begin
      g.data[0] = {5'b11110, cp[20:18]};
      g.data[1] = {2'b10, cp[17:12]};
      g.data[2] = {2'b10, cp[11:6]};
      g.data[3] = {2'b10, cp[5:0]};
      g.num     = 2'd3;
    end
    return g;
  endfunction

endpackage

### hdl/jsu_ifs.sv
// ============================================================================
// jsu_ifs: valid/ready channels of the JSON string unescaper
// One channel for JSON text bytes and one for decoded result items.
// ============================================================================
interface jsu_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface jsu_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic [2:0] error_code;
  logic       last;

  modport source (output valid, output out_byte, output kind, output error_code,
                  output last, input ready);
  modport sink (input valid, input out_byte, input kind, input error_code,
                input last, output ready);
endinterface

### hdl/jsu_decode.sv
// ============================================================================
// jsu_decode: input register and string decode step
// Holds the parser state and turns one registered text byte into a group
// of zero to four results and the next parser state.
// ============================================================================
module jsu_decode (
  input  logic          clk,
  input  logic          rst,
  jsu_text_if.sink      text,
  input  logic          grp_free,
  output logic          grp_push,
  output jsu_pkg::grp_t grp_new
);

  typedef enum logic [2:0] {
    IDLE    = 3'd0,
    STR     = 3'd1,
    ESC     = 3'd2,
    HEX1    = 3'd3,
    WAIT_BS = 3'd4,
    WAIT_U  = 3'd5,
    HEX2    = 3'd6
  } mode_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  logic        ireg_valid;
  logic [7:0]  ireg_byte;
  logic        ireg_eoi;
  logic        take;

  mode_t       mode, mode_next;
  logic [1:0]  hex_cnt, hex_cnt_next;
  logic [11:0] code_unit, code_unit_next;
  logic [9:0]  hs_bits, hs_bits_next;

  logic        has;
  jsu_pkg::grp_t grp_c;
  jsu_pkg::hex_t hv;
  logic [15:0] unit;

  // An item leaves the input register when its results have room.
  assign take       = ireg_valid && (!has || grp_free);
  assign text.ready = !ireg_valid || take;
  assign grp_push   = ireg_valid && has && grp_free;
  assign grp_new    = grp_c;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ireg_valid <= 1'b0;
    end else if (text.ready) begin
      ireg_valid <= text.valid;
    end
    if (text.ready && text.valid) begin
      ireg_byte <= text.in_byte;
      ireg_eoi  <= text.end_of_input;
    end
  end

  // Parser state, updated when the registered item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= IDLE;
      hex_cnt   <= 2'd0;
      code_unit <= 12'd0;
      hs_bits   <= 10'd0;
    end else if (take) begin
      mode      <= mode_next;
      hex_cnt   <= hex_cnt_next;
      code_unit <= code_unit_next;
      hs_bits   <= hs_bits_next;
    end
  end

  assign hv   = jsu_pkg::hex_value(ireg_byte);
  assign unit = {code_unit, hv.val};

  // Decode step for one byte of text or the end of input.
  always_comb begin
    mode_next      = mode;
    hex_cnt_next   = hex_cnt;
    code_unit_next = code_unit;
    hs_bits_next   = hs_bits;
    has            = 1'b0;
    grp_c          = jsu_pkg::single(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_NONE);

    if (ireg_eoi) begin
      case (mode)
        STR, ESC, HEX1, HEX2: begin
          has   = 1'b1;
          grp_c = jsu_pkg::single(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_END);
        end
        WAIT_BS, WAIT_U: begin
          has   = 1'b1;
          grp_c = jsu_pkg::single(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_UNICODE);
        end
        default: begin
        end
      endcase
      mode_next      = IDLE;
      hex_cnt_next   = 2'd0;
      code_unit_next = 12'd0;
      hs_bits_next   = 10'd0;
    end else begin
      case (mode)
        STR: begin
          has = 1'b1;
          if (ireg_byte == CH_QUOTE) begin
            grp_c     = jsu_pkg::single(8'h00, jsu_pkg::KIND_CLOSE, jsu_pkg::ERR_NONE);
            mode_next = IDLE;
          end else if (ireg_byte < 8'h20) begin
            grp_c     = jsu_pkg::single(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_TOKEN);
            mode_next = IDLE;
          end else if (ireg_byte == CH_BSLASH) begin
            has       = 1'b0;
            mode_next = ESC;
          end else begin
            grp_c = jsu_pkg::single(ireg_byte, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
          end
        end

        ESC: begin
          has       = 1'b1;
          mode_next = STR;
          case (ireg_byte)
            CH_QUOTE, CH_BSLASH, CH_SLASH:
              grp_c = jsu_pkg::single(ireg_byte, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
            CH_B: grp_c = jsu_pkg::single(8'h08, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
            CH_F: grp_c = jsu_pkg::single(8'h0C, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
            CH_N: grp_c = jsu_pkg::single(8'h0A, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
            CH_R: grp_c = jsu_pkg::single(8'h0D, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
            CH_T: grp_c = jsu_pkg::single(8'h09, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
            CH_U: begin
              has            = 1'b0;
              mode_next      = HEX1;
              hex_cnt_next   = 2'd0;
              code_unit_next = 12'd0;
            end
            default: begin
              grp_c     = jsu_pkg::single(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_ESCAPE);
              mode_next = IDLE;
            end
          endcase
        end

        HEX1, HEX2: begin
          if (!hv.ok) begin
            has       = 1'b1;
            grp_c     = jsu_pkg::single(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_UNICODE);
            mode_next = IDLE;
          end else if (hex_cnt != 2'd3) begin
            hex_cnt_next   = hex_cnt + 2'd1;
            code_unit_next = unit[11:0];
          end else begin
            hex_cnt_next   = 2'd0;
            code_unit_next = unit[11:0];
            if (mode == HEX1) begin
              // First unit: a high surrogate waits for its partner.
              if (unit[15:10] == 6'b110110) begin
                hs_bits_next = unit[9:0];
                mode_next    = WAIT_BS;
              end else if (unit[15:10] == 6'b110111) begin
                has       = 1'b1;
                grp_c     = jsu_pkg::single(8'h00, jsu_pkg::KIND_ERROR,
                                            jsu_pkg::ERR_UNICODE);
                mode_next = IDLE;
              end else begin
                has       = 1'b1;
                grp_c     = jsu_pkg::utf8({5'd0, unit});
                mode_next = STR;
              end
            end else begin
              // Second unit must be a low surrogate; combine the pair.
              has = 1'b1;
              if (unit[15:10] != 6'b110111) begin
                grp_c     = jsu_pkg::single(8'h00, jsu_pkg::KIND_ERROR,
                                            jsu_pkg::ERR_UNICODE);
                mode_next = IDLE;
              end else begin
                grp_c        = jsu_pkg::utf8({({1'b0, hs_bits} + 11'd64), unit[9:0]});
                mode_next    = STR;
                hs_bits_next = 10'd0;
              end
            end
          end
        end

        WAIT_BS, WAIT_U: begin
          if ((mode == WAIT_BS) && (ireg_byte == CH_BSLASH)) begin
            mode_next = WAIT_U;
          end else if ((mode == WAIT_U) && (ireg_byte == CH_U)) begin
            mode_next      = HEX2;
            hex_cnt_next   = 2'd0;
            code_unit_next = 12'd0;
          end else if (!jsu_pkg::is_space(ireg_byte)) begin
            has       = 1'b1;
            grp_c     = jsu_pkg::single(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_UNICODE);
            mode_next = IDLE;
          end
        end

        default: begin
          mode_next = IDLE;
          if (ireg_byte == CH_QUOTE) begin
            mode_next = STR;
          end else if (!jsu_pkg::is_space(ireg_byte)) begin
            has   = 1'b1;
            grp_c = jsu_pkg::single(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_TOKEN);
          end
        end
      endcase

      // Leaving a string, normally or by error, clears all state.
      if (mode_next == IDLE) begin
        hex_cnt_next   = 2'd0;
        code_unit_next = 12'd0;
        hs_bits_next   = 10'd0;
      end
    end
  end

endmodule

### hdl/jsu_emit.sv
// ============================================================================
// jsu_emit: result register and serializer
// Holds one group of results, handed out one item per cycle unless stalled.
// ============================================================================
module jsu_emit (
  input  logic          clk,
  input  logic          rst,
  input  logic          grp_push,
  input  jsu_pkg::grp_t grp_new,
  output logic          grp_free,
  jsu_result_if.source  decoded
);

  jsu_pkg::grp_t grp;
  logic          grp_valid;
  logic [1:0]    idx;
  logic          fire;

  assign fire     = decoded.valid && decoded.ready;
  assign grp_free = !grp_valid || (fire && decoded.last);

  // Output item fields come straight from the result register.
  assign decoded.valid      = grp_valid;
  assign decoded.out_byte   = grp.data[idx];
  assign decoded.kind       = grp.kind;
  assign decoded.error_code = grp.err;
  assign decoded.last       = (idx == grp.num);

  // Control: group occupancy and position within the group.
  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (grp_push) begin
      grp_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (fire) begin
      if (decoded.last) begin
        grp_valid <= 1'b0;
        idx       <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (grp_push) begin
      grp <= grp_new;
    end
  end

`ifndef SYNTH
  a_idx_in_group: assert property (@(posedge clk) disable iff (rst)
    grp_valid |-> (idx <= grp.num))
    else $error("result index beyond group size");

  a_error_has_code: assert property (@(posedge clk) disable iff (rst)
    (decoded.valid && (decoded.kind == jsu_pkg::KIND_ERROR))
      |-> (decoded.error_code != jsu_pkg::ERR_NONE))
    else $error("error item without error code");

  a_marker_is_last: assert property (@(posedge clk) disable iff (rst)
    (decoded.valid && (decoded.kind != jsu_pkg::KIND_BYTE)) |-> decoded.last)
    else $error("end marker or error not last in its group");

  a_push_only_free: assert property (@(posedge clk) disable iff (rst)
    grp_push |-> grp_free)
    else $error("group loaded while results still pending");
`endif

endmodule

### hdl/json_string_unescape_utf8_unit.sv
// ============================================================================
// json_string_unescape_utf8_unit: JSON string unescaper with UTF-8 output
// Decodes quoted JSON strings from a byte stream into UTF-8 bytes, an end
// marker per closed string, or an error code.
// ============================================================================
// Takes one byte of JSON text per cycle unless the input stalls, and delivers
// results through an input register and a result register. Each input
// item yields zero or more results; a result group is held in the result
// register and handed out one item per cycle while the output is ready. The
// next input item is accepted while a group is waiting, and is held in the
// input register if it has results of its own and the group has not yet
// drained; the input then stalls until the last result of the group is taken.
// With the output always ready, items that give at most one result go
// through at one per cycle. A \u escape that gives n UTF-8 bytes can hold a
// text byte with results that follows it directly until its last byte is
// taken, while bytes without results, such as the backslash and hex digits
// of a following escape, pass during the drain.
// After reset the block is idle, skipping whitespace until an opening quote.
module json_string_unescape_utf8_unit (
  input  logic         clk,
  input  logic         rst,
  jsu_text_if.sink     text,
  jsu_result_if.source decoded
);

  logic          grp_push;
  logic          grp_free;
  jsu_pkg::grp_t grp_new;

  // Decode step with input register and parser state.
  jsu_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .text     (text),
    .grp_free (grp_free),
    .grp_push (grp_push),
    .grp_new  (grp_new)
  );

  // Result register and serializer.
  jsu_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .grp_push (grp_push),
    .grp_new  (grp_new),
    .grp_free (grp_free),
    .decoded  (decoded)
  );

endmodule

### verif/jsu_unescape_checker.sv
// ============================================================================
// jsu_unescape_checker: result checker for the JSON string unescaper
// Watches the text and result channels. Every accepted text item runs
// through a cycle-free decoder that builds the UTF-8 bytes, end markers and
// error codes it should give. Every accepted result item is compared field
// by field with the oldest of those.
// ============================================================================
module jsu_unescape_checker (
  input  logic        clk,
  input  logic        rst,
  jsu_text_if         text,
  jsu_result_if       decoded,
  output int unsigned mismatches,
  output int unsigned results_owed
);

  // Where the decoder stands in the text.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BODY,
    ST_ESCAPE,
    ST_HEX_FIRST,
    ST_WANT_BSLASH,
    ST_WANT_U,
    ST_HEX_LOW
  } scan_state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [2:0] error_code;
    logic       last;
  } decoded_item_t;

  scan_state_t   scan_state;
  logic [1:0]    digits_seen;
  logic [15:0]   unit_value;
  logic [9:0]    high_bits;
  decoded_item_t step_items[$];
  decoded_item_t owed_items[$];

  function automatic void clear_scan();
    scan_state  = ST_IDLE;
    digits_seen = 2'd0;
    unit_value  = 16'h0000;
    high_bits   = 10'd0;
  endfunction

  function automatic void add_item(input logic [7:0] b, input logic [1:0] k,
                                   input logic [2:0] e);
    decoded_item_t r;
    r.out_byte   = b;
    r.kind       = k;
    r.error_code = e;
    r.last       = 1'b0;
    step_items.insert(step_items.size(), r);
  endfunction

  // An error ends the string and sends the decoder back to idle.
  function automatic void abort_string(input logic [2:0] e);
    add_item(8'h00, jsu_pkg::KIND_ERROR, e);
    clear_scan();
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // Returns {valid, value} for one hex digit.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= "0" && c <= "9") begin
      v = c - "0";
    end else if (c >= "a" && c <= "f") begin
      v = c - 8'h57;
    end else if (c >= "A" && c <= "F") begin
      v = c - 8'h37;
    end else begin
      return 5'h00;
    end
    return {1'b1, v[3:0]};
  endfunction

  // UTF-8 bytes of one code point, lead byte first.
  function automatic void add_code_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      add_item(cp[7:0], jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
    end else if (cp < 21'h800) begin
      add_item(8'hC0 | 8'(cp >> 6), jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
      add_item(8'h80 | (8'(cp) & 8'h3F), jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
    end else if (cp < 21'h10000) begin
      add_item(8'hE0 | 8'(cp >> 12), jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
      add_item(8'h80 | (8'(cp >> 6) & 8'h3F), jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
      add_item(8'h80 | (8'(cp) & 8'h3F), jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
    end else begin
      add_item(8'hF0 | 8'(cp >> 18), jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
      add_item(8'h80 | (8'(cp >> 12) & 8'h3F), jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
      add_item(8'h80 | (8'(cp >> 6) & 8'h3F), jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
      add_item(8'h80 | (8'(cp) & 8'h3F), jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
    end
  endfunction

  // Takes one hex digit; returns 1 once four digits form a unit.
  function automatic logic take_digit(input logic [7:0] c);
    logic [4:0] h;
    h = hex_nibble(c);
    if (!h[4]) begin
      abort_string(jsu_pkg::ERR_UNICODE);
      return 1'b0;
    end
    unit_value = {unit_value[11:0], h[3:0]};
    if (digits_seen == 2'd3) begin
      digits_seen = 2'd0;
      return 1'b1;
    end
    digits_seen = digits_seen + 2'd1;
    return 1'b0;
  endfunction

  // Decodes one text item and queues the result items it should give.
  function automatic void decode_text_item(input logic [7:0] b, input logic eoi);
    logic [7:0] plain;
    logic       known;
    step_items.delete();
    plain = 8'h00;
    known = 1'b1;
    if (eoi) begin
      case (scan_state)
        ST_BODY, ST_ESCAPE, ST_HEX_FIRST, ST_HEX_LOW: abort_string(jsu_pkg::ERR_END);
        ST_WANT_BSLASH, ST_WANT_U: abort_string(jsu_pkg::ERR_UNICODE);
        default: clear_scan();
      endcase
    end else begin
      case (scan_state)
        ST_BODY: begin
          if (b == "\"") begin
            add_item(8'h00, jsu_pkg::KIND_CLOSE, jsu_pkg::ERR_NONE);
            clear_scan();
          end else if (b < 8'h20) begin
            abort_string(jsu_pkg::ERR_TOKEN);
          end else if (b == "\\") begin
            scan_state = ST_ESCAPE;
          end else begin
            add_item(b, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
          end
        end
        ST_ESCAPE: begin
          if (b == "u") begin
            scan_state  = ST_HEX_FIRST;
            digits_seen = 2'd0;
            unit_value  = 16'h0000;
          end else begin
            case (b)
              "\"", "\\", "/": plain = b;
              "b": plain = 8'h08;
              "f": plain = 8'h0C;
              "n": plain = 8'h0A;
              "r": plain = 8'h0D;
              "t": plain = 8'h09;
              default: known = 1'b0;
            endcase
            if (known) begin
              add_item(plain, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
              scan_state = ST_BODY;
            end else begin
              abort_string(jsu_pkg::ERR_ESCAPE);
            end
          end
        end
        ST_HEX_FIRST: begin
          if (take_digit(b)) begin
            if (unit_value >= 16'hD800 && unit_value <= 16'hDBFF) begin
              high_bits  = unit_value[9:0];
              scan_state = ST_WANT_BSLASH;
            end else if (unit_value >= 16'hDC00 && unit_value <= 16'hDFFF) begin
              abort_string(jsu_pkg::ERR_UNICODE);
            end else begin
              add_code_point({5'd0, unit_value});
              scan_state = ST_BODY;
            end
          end
        end
        ST_WANT_BSLASH: begin
          if (b == "\\") begin
            scan_state = ST_WANT_U;
          end else if (!is_blank(b)) begin
            abort_string(jsu_pkg::ERR_UNICODE);
          end
        end
        ST_WANT_U: begin
          if (b == "u") begin
            scan_state  = ST_HEX_LOW;
            digits_seen = 2'd0;
            unit_value  = 16'h0000;
          end else if (!is_blank(b)) begin
            abort_string(jsu_pkg::ERR_UNICODE);
          end
        end
        ST_HEX_LOW: begin
          if (take_digit(b)) begin
            if (unit_value < 16'hDC00 || unit_value > 16'hDFFF) begin
              abort_string(jsu_pkg::ERR_UNICODE);
            end else begin
              // The pair carries twenty bits above the basic plane.
              add_code_point(21'h10000 + {1'b0, high_bits, unit_value[9:0]});
              scan_state = ST_BODY;
              high_bits  = 10'd0;
            end
          end
        end
        default: begin
          if (b == "\"") begin
            clear_scan();
            scan_state = ST_BODY;
          end else if (!is_blank(b)) begin
            abort_string(jsu_pkg::ERR_TOKEN);
          end else begin
            clear_scan();
          end
        end
      endcase
    end
    // Mark the final item of this step and hand the batch to the checker.
    foreach (step_items[i]) begin
      plain = 8'h00;
      step_items[i].last = (i == step_items.size() - 1);
      owed_items.insert(owed_items.size(), step_items[i]);
    end
  endfunction

  // Predict on accepted text items and compare accepted result items.
  always @(posedge clk) begin
    decoded_item_t want;
    if (rst) begin
      clear_scan();
      owed_items.delete();
      mismatches   <= 0;
      results_owed <= 0;
    end else begin
      if (text.valid && text.ready) begin
        decode_text_item(text.in_byte, text.end_of_input);
      end
      if (decoded.valid && decoded.ready) begin
        if (owed_items.size() == 0) begin
          $error("result item with nothing expected: out_byte 0x%h kind %0d error_code %0d",
                 decoded.out_byte, decoded.kind, decoded.error_code);
          mismatches <= mismatches + 1;
        end else begin
          want = owed_items.pop_front();
          if (decoded.out_byte !== want.out_byte) begin
            $error("out_byte: expected 0x%h, got 0x%h", want.out_byte, decoded.out_byte);
          end
          if (decoded.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, decoded.kind);
          end
          if (decoded.error_code !== want.error_code) begin
            $error("error_code: expected %0d, got %0d", want.error_code,
                   decoded.error_code);
          end
          if (decoded.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, decoded.last);
          end
          if (decoded.out_byte !== want.out_byte || decoded.kind !== want.kind ||
              decoded.error_code !== want.error_code || decoded.last !== want.last) begin
            mismatches <= mismatches + 1;
          end
        end
      end
      results_owed <= owed_items.size();
    end
  end

endmodule

### verif/tb.sv
// ============================================================================
// tb: testbench top for json_string_unescape_utf8_unit
// Feeds a byte stream of JSON text, a short directed opening followed by
// random well-formed and broken strings, in bursts with random gaps, while
// the result side stalls on its own pattern and once holds off for a long
// stretch. A separate checker predicts and compares every result item.
// ============================================================================
module tb;

  localparam int unsigned RANDOM_ITEMS = 210;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_START   = 40;
  localparam int unsigned HOLD_CYCLES  = 90;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } text_item_t;

  logic         clk = 1'b0;
  logic         rst;
  int unsigned  mismatches;
  int unsigned  results_owed;
  int unsigned  idle_cycles;
  int unsigned  stream_count;
  text_item_t   text_items[$];

  jsu_text_if   text_ch ();
  jsu_result_if result_ch ();

  json_string_unescape_utf8_unit uut (
    .clk     (clk),
    .rst     (rst),
    .text    (text_ch),
    .decoded (result_ch)
  );

  jsu_unescape_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .text         (text_ch),
    .decoded      (result_ch),
    .mismatches   (mismatches),
    .results_owed (results_owed)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- stimulus

  function automatic void add_text(input logic [7:0] b);
    text_item_t t;
    t.in_byte      = b;
    t.end_of_input = 1'b0;
    text_items.insert(text_items.size(), t);
    stream_count++;
  endfunction

  // End of input; the byte lane carries noise.
  function automatic void add_end();
    text_item_t t;
    t.in_byte      = 8'($urandom);
    t.end_of_input = 1'b1;
    text_items.insert(text_items.size(), t);
    stream_count++;
  endfunction

  function automatic void add_chars(input string s);
    for (int i = 0; i < s.len(); i++) begin
      add_text(s[i]);
    end
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic void add_blanks(input int unsigned most);
    int unsigned k;
    repeat ($urandom_range(0, most)) begin
      k = $urandom_range(0, 5);
      add_text((k == 5) ? 8'h20 : 8'h09 + 8'(k));
    end
  endfunction

  // Hex digit in random letter case.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return 8'h30 + 8'(nib);
    end
    return (($urandom_range(0, 1) == 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_char();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(8'h00, 8'h2F));
      1: return 8'($urandom_range(8'h3A, 8'h40));
      2: return 8'($urandom_range(8'h47, 8'h60));
      default: return 8'($urandom_range(8'h67, 8'hFF));
    endcase
  endfunction

  function automatic void add_unit(input logic [15:0] u);
    for (int i = 3; i >= 0; i--) begin
      add_text(hex_char(u[i*4 +: 4]));
    end
  endfunction

  function automatic void add_high_unit();
    add_chars("\\u");
    add_unit(16'hD800 | 16'($urandom_range(0, 1023)));
  endfunction

  // One piece of a string body: raw byte, simple escape, \u unit or pair.
  function automatic void add_body_piece();
    logic [7:0]  b;
    logic [15:0] u;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        do b = 8'($urandom_range(8'h20, 8'hFF)); while (b == "\"" || b == "\\");
        add_text(b);
      end
      4, 5: begin
        add_text("\\");
        case ($urandom_range(0, 7))
          0: add_text("\"");
          1: add_text("\\");
          2: add_text("/");
          3: add_text("b");
          4: add_text("f");
          5: add_text("n");
          6: add_text("r");
          default: add_text("t");
        endcase
      end
      6, 7: begin
        case ($urandom_range(0, 3))
          0: u = 16'($urandom_range(16'h0000, 16'h007F));
          1: u = 16'($urandom_range(16'h0080, 16'h07FF));
          2: do u = 16'($urandom_range(16'h0800, 16'hFFFF));
             while (u >= 16'hD800 && u <= 16'hDFFF);
          default: begin
            case ($urandom_range(0, 5))
              0: u = 16'h0000;
              1: u = 16'h007F;
              2: u = 16'h0080;
              3: u = 16'h07FF;
              4: u = 16'h0800;
              default: u = 16'hFFFF;
            endcase
          end
        endcase
        add_chars("\\u");
        add_unit(u);
      end
      default: begin
        add_high_unit();
        add_blanks(2);
        add_text("\\");
        add_blanks(2);
        add_text("u");
        add_unit(16'hDC00 | 16'($urandom_range(0, 1023)));
      end
    endcase
  endfunction

  function automatic void add_body(input int unsigned most);
    repeat ($urandom_range(0, most)) add_body_piece();
  endfunction

  // A string that breaks in one of the ways the decoder must flag.
  function automatic void add_broken_text();
    logic [7:0]  b;
    logic [15:0] u;
    int unsigned flaw;
    int unsigned k;
    flaw = $urandom_range(0, 9);
    case (flaw)
      0: begin
        // Stray byte while idle.
        do b = 8'($urandom); while (is_blank(b) || b == "\"");
        add_text(b);
      end
      1: begin
        // Raw control byte inside a string.
        add_text("\"");
        add_body(2);
        add_text(8'($urandom_range(8'h00, 8'h1F)));
      end
      2: begin
        // Unknown escape letter.
        add_text("\"");
        add_body(2);
        add_text("\\");
        do b = 8'($urandom);
        while (b == "\"" || b == "\\" || b == "/" || b == "b" || b == "f" || b == "n" ||
               b == "r" || b == "t" || b == "u");
        add_text(b);
      end
      3: begin
        // Non-hex digit in the first unit.
        add_chars("\"\\u");
        repeat ($urandom_range(0, 3)) add_text(hex_char(4'($urandom)));
        add_text(non_hex_char());
      end
      4: begin
        // Low surrogate with no high one before it.
        add_chars("\"\\u");
        add_unit(16'hDC00 | 16'($urandom_range(0, 1023)));
      end
      5: begin
        // High surrogate not followed by a backslash.
        add_text("\"");
        add_high_unit();
        add_blanks(2);
        do b = 8'($urandom); while (is_blank(b) || b == "\\");
        add_text(b);
      end
      6: begin
        // Backslash after a high surrogate not followed by 'u'.
        add_text("\"");
        add_high_unit();
        add_blanks(1);
        add_text("\\");
        add_blanks(2);
        do b = 8'($urandom); while (is_blank(b) || b == "u");
        add_text(b);
      end
      7: begin
        // Second unit that is no low surrogate, or holds a bad digit.
        add_text("\"");
        add_high_unit();
        add_blanks(1);
        add_chars("\\u");
        if ($urandom_range(0, 1) == 1) begin
          do u = 16'($urandom); while (u >= 16'hDC00 && u <= 16'hDFFF);
          add_unit(u);
        end else begin
          repeat ($urandom_range(0, 3)) add_text(hex_char(4'($urandom)));
          add_text(non_hex_char());
        end
      end
      8: begin
        // Input ends at some point inside a string.
        add_text("\"");
        add_body(2);
        k = $urandom_range(0, 5);
        if (k == 1) begin
          add_text("\\");
        end else if (k == 2) begin
          add_chars("\\u");
          repeat ($urandom_range(0, 3)) add_text(hex_char(4'($urandom)));
        end else if (k >= 3) begin
          add_high_unit();
          add_blanks(1);
          if (k >= 4) begin
            add_text("\\");
            add_blanks(1);
          end
          if (k == 5) begin
            add_text("u");
            repeat ($urandom_range(0, 3)) add_text(hex_char(4'($urandom)));
          end
        end
        add_end();
      end
      default: begin
        // Pure noise, closed by an end of input.
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 4) == 0) add_end();
          else add_text(8'($urandom));
        end
        add_end();
      end
    endcase
    // The rest of a broken string is handled from idle.
    if (flaw >= 1 && flaw <= 7 && $urandom_range(0, 1) == 1) begin
      repeat ($urandom_range(1, 3)) add_text(8'($urandom_range(8'h20, 8'h7E)));
      add_end();
    end
  endfunction

  function automatic void build_stream();
    // Directed opening: idle skips, stray byte, end while idle, the extreme
    // raw bytes, a bad escape, and the highest code point as a surrogate
    // pair with blanks inside, then end of input inside the string.
    add_text(8'h0B);
    add_text("x");
    add_end();
    add_text("\"");
    add_text(8'hFF);
    add_text(8'h1F);
    add_chars("\"\\q");
    add_chars("\"\\udBfF \\");
    add_text(8'h0D);
    add_chars("uDFFF");
    add_end();

    // Random part: mostly well-formed strings, the rest broken ones.
    stream_count = 0;
    while (stream_count < RANDOM_ITEMS) begin
      add_blanks(2);
      if ($urandom_range(0, 99) < 65) begin
        add_text("\"");
        add_body(6);
        add_text("\"");
        if ($urandom_range(0, 4) == 0) add_end();
      end else begin
        add_broken_text();
      end
    end
  endfunction

  // Reset, send the stream in bursts, wait for the last results, judge.
  initial begin : text_feed
    int unsigned pos;
    int unsigned burst;
    int unsigned gap;
    rst                  = 1'b1;
    text_ch.valid        = 1'b0;
    text_ch.in_byte      = 8'h00;
    text_ch.end_of_input = 1'b0;
    build_stream();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    pos = 0;
    while (pos < text_items.size()) begin
      burst = $urandom_range(1, 16);
      while (burst > 0 && pos < text_items.size()) begin
        text_ch.valid        <= 1'b1;
        text_ch.in_byte      <= text_items[pos].in_byte;
        text_ch.end_of_input <= text_items[pos].end_of_input;
        @(posedge clk);
        while (!text_ch.ready) @(posedge clk);
        @(negedge clk);
        pos++;
        burst--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        text_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    text_ch.valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("json_string_unescape_utf8_unit test passed");
    end else begin
      $display("json_string_unescape_utf8_unit test failed");
    end
    $finish;
  end

  // Result side: a stall style that is redrawn at random, and one long
  // hold-off early on so the block backs up into its text input.
  initial begin : result_drain
    int unsigned cyc;
    int unsigned style;
    cyc   = 0;
    style = 0;
    result_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (cyc % 40 == 0) style = $urandom_range(0, 3);
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES) begin
        result_ch.ready <= 1'b0;
      end else begin
        case (style)
          0: result_ch.ready <= 1'b1;
          1: result_ch.ready <= ($urandom_range(0, 1) == 1);
          2: result_ch.ready <= (cyc % 3 == 0);
          default: result_ch.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
      cyc++;
      @(negedge clk);
    end
  end

  // Watchdog: too many cycles in a row with no item accepted on either side.
  always @(posedge clk) begin
    if (rst || (text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("json_string_unescape_utf8_unit test failed");
      $finish;
    end
  end

endmodule

### filelist.f
hdl/jsu_pkg.sv
hdl/jsu_ifs.sv
hdl/jsu_decode.sv
hdl/jsu_emit.sv
hdl/json_string_unescape_utf8_unit.sv
verif/jsu_unescape_checker.sv
verif/tb.sv
